>>> sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/rth_pkg.sv
`default_nettype none

package rth_pkg;

  // channel and quotient widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned QuotW  = 8;
  // hue numerator over 6*delta, 0 .. 1529
  localparam int unsigned NumW   = 11;
  // saturation division: (510*delta + max) / (2*max)
  localparam int unsigned SatNW  = 17;
  localparam int unsigned SatDW  = 9;
  // hue division: (510*num + 6*delta) / (12*delta)
  localparam int unsigned HueNW  = 20;
  localparam int unsigned HueDW  = 12;
  // front stage, dividend stage, one stage per quotient bit
  localparam int unsigned PipeDepth = QuotW + 2;
  // full scale times two, for half-up rounding
  localparam int unsigned ScaleX2 = 510;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } rgb_t;

  typedef struct packed {
    logic [ChanW-1:0] hue_out;
    logic [ChanW-1:0] saturation_out;
    logic [ChanW-1:0] value_out;
  } hsv_t;

endpackage

`default_nettype wire

>>> sv/rth_stream_if.sv
`default_nettype none

// valid/ready channel carrying one item of type T
interface rth_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/rgb_to_hsv_8bit.sv
// rgb_to_hsv_8bit: streaming 8-bit rgb to hsv conversion
//
// pix_i (sink, payload rth_pkg::rgb_t) takes one pixel per item; hsv_o
// (source, payload rth_pkg::hsv_t) gives one hue/saturation/value item per
// pixel, in order. both channels move an item when valid and ready are high.
//
// the pipe has 10 register stages: one stage for max/min and the hue
// numerator, one for the dividends, then eight stages of a pipelined
// restoring divider, one quotient bit each, for hue and saturation side by
// side. it takes one item per cycle while hsv_o.ready is high.
//
// each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves on, so bubbles close up and pix_i.ready stays high
// while any stage is free. when hsv_o.ready is low the output item holds and
// the pipe fills behind it; no item is lost or repeated.
//
// rst_ni (asynchronous, active low) empties the pipe; hsv_o.valid is low
// after reset. the block holds no state between pixels.
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsv_8bit (
  input  logic          clk_i,
  input  logic          rst_ni,
  rth_stream_if.sink    pix_i,
  rth_stream_if.source  hsv_o
);
  import rth_pkg::*;

  // handshake per stage
  logic [PipeDepth-1:0] vld_q;
  logic [PipeDepth-1:0] rdy;
  logic [PipeDepth-1:0] vld_in;

  // front stage registers
  logic [ChanW-1:0] fr_max_q, fr_max_d;
  logic [ChanW-1:0] fr_dlt_q, fr_dlt_d;
  logic [NumW-1:0]  fr_num_q, fr_num_d;

  // divider stage registers, index 0 is the dividend stage
  logic [HueNW-1:0] hrem_q [0:QuotW];
  logic [HueDW-1:0] hden_q [0:QuotW];
  logic [SatNW-1:0] srem_q [0:QuotW];
  logic [SatDW-1:0] sden_q [0:QuotW];
  logic [QuotW-1:0] hquo_q [0:QuotW];
  logic [QuotW-1:0] squo_q [0:QuotW];
  logic [ChanW-1:0] vmax_q [0:QuotW];
  logic             gray_q [0:QuotW];

  // ready chain from the output back to the input
  assign rdy[PipeDepth-1] = !vld_q[PipeDepth-1] || hsv_o.ready;
  for (genvar k = 0; k < PipeDepth - 1; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  assign vld_in = {vld_q[PipeDepth-2:0], pix_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < PipeDepth; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign pix_i.ready = rdy[0];

  // front stage: max, min, delta and the wrapped hue numerator
  always_comb begin
    logic [ChanW-1:0]     r, g, b, mn;
    logic                 r_max, g_max;
    logic signed [NumW:0] num;
    logic signed [NumW:0] six_d;
    r      = pix_i.data.red_in;
    g      = pix_i.data.green_in;
    b      = pix_i.data.blue_in;
    r_max  = (r >= g) && (r >= b);
    g_max  = !r_max && (g >= b);
    priority if (r_max) fr_max_d = r;
    else if (g_max)     fr_max_d = g;
    else                fr_max_d = b;
    mn = (r <= g) ? r : g;
    mn = (mn <= b) ? mn : b;
    fr_dlt_d = fr_max_d - mn;
    six_d = (NumW+1)'({fr_dlt_d, 2'b00}) + (NumW+1)'({fr_dlt_d, 1'b0});
    priority if (r_max) begin
      num = (NumW+1)'(g) - (NumW+1)'(b);
    end else if (g_max) begin
      num = (NumW+1)'({fr_dlt_d, 1'b0}) + (NumW+1)'(b) - (NumW+1)'(r);
    end else begin
      num = (NumW+1)'({fr_dlt_d, 2'b00}) + (NumW+1)'(r) - (NumW+1)'(g);
    end
    // negative hue wraps by one full turn
    if (num < 0) begin
      num = num + six_d;
    end
    fr_num_d = num[NumW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vld_in[0]) begin
      fr_max_q <= fr_max_d;
      fr_dlt_q <= fr_dlt_d;
      fr_num_q <= fr_num_d;
    end
  end

  // dividend stage: scale numerators, form divisors
  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld_in[1]) begin
      hrem_q[0] <= HueNW'(fr_num_q) * HueNW'(ScaleX2)
                 + HueNW'({fr_dlt_q, 2'b00}) + HueNW'({fr_dlt_q, 1'b0});
      hden_q[0] <= HueDW'({fr_dlt_q, 3'b000}) + HueDW'({fr_dlt_q, 2'b00});
      srem_q[0] <= SatNW'(fr_dlt_q) * SatNW'(ScaleX2) + SatNW'(fr_max_q);
      sden_q[0] <= {fr_max_q, 1'b0};
      hquo_q[0] <= '0;
      squo_q[0] <= '0;
      vmax_q[0] <= fr_max_q;
      gray_q[0] <= (fr_dlt_q == '0);
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < QuotW; j++) begin : g_div
    localparam int unsigned Sh = QuotW - 1 - j;
    logic [HueNW-1:0] hsh;
    logic [SatNW-1:0] ssh;
    logic             hge, sge;

    assign hsh = HueNW'(hden_q[j]) << Sh;
    assign ssh = SatNW'(sden_q[j]) << Sh;
    assign hge = hrem_q[j] >= hsh;
    assign sge = srem_q[j] >= ssh;

    always_ff @(posedge clk_i) begin
      if (rdy[j+2] && vld_in[j+2]) begin
        hrem_q[j+1] <= hge ? hrem_q[j] - hsh : hrem_q[j];
        srem_q[j+1] <= sge ? srem_q[j] - ssh : srem_q[j];
        hden_q[j+1] <= hden_q[j];
        sden_q[j+1] <= sden_q[j];
        hquo_q[j+1] <= {hquo_q[j][QuotW-2:0], hge};
        squo_q[j+1] <= {squo_q[j][QuotW-2:0], sge};
        vmax_q[j+1] <= vmax_q[j];
        gray_q[j+1] <= gray_q[j];
      end
    end
  end

  // output item, gray pixels get zero hue and saturation
  assign hsv_o.valid               = vld_q[PipeDepth-1];
  assign hsv_o.data.hue_out        = gray_q[QuotW] ? '0 : hquo_q[QuotW];
  assign hsv_o.data.saturation_out = gray_q[QuotW] ? '0 : squo_q[QuotW];
  assign hsv_o.data.value_out      = vmax_q[QuotW];

  // checks
  `ASSERT_NEXT(a_enter_front, clk_i, rst_ni, pix_i.valid && pix_i.ready, vld_q[0])
  `ASSERT_IMPL(a_black_zero, clk_i, rst_ni, hsv_o.valid && (hsv_o.data.value_out == '0), (hsv_o.data.hue_out == '0) && (hsv_o.data.saturation_out == '0))
  `ASSERT_IMPL(a_unsat_no_hue, clk_i, rst_ni, hsv_o.valid && (hsv_o.data.saturation_out == '0), hsv_o.data.hue_out == '0)

endmodule

`default_nettype wire
